[rtl/core/pip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared codes and types of the point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Width of one signed coordinate on the command channel.
  localparam int COORD_BITS = 16;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_TEST  = 2'd2;

  // Status of the crossing unit seen by the sequencer.
  typedef struct packed {
    logic busy;     // some edge still in flight inside the unit
    logic hit_vld;  // an edge result is present this cycle
    logic hit;      // that edge crosses the ray
  } pip_stat_t;

endpackage

[rtl/core/pip_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_in_if / pip_out_if
// Valid/ready channels for commands and for results.
// ----------------------------------------------------------------------------
interface pip_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            func;
  logic signed [pip_pkg::COORD_BITS-1:0] ax;
  logic signed [pip_pkg::COORD_BITS-1:0] ay;
  logic signed [pip_pkg::COORD_BITS-1:0] bx;
  logic signed [pip_pkg::COORD_BITS-1:0] by;
  logic                                  last_point;

  modport source (output valid, func, ax, ay, bx, by, last_point, input ready);
  modport sink   (input valid, func, ax, ay, bx, by, last_point, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic any_inside;
  logic table_full;

  modport source (output valid, inside_res, any_inside, table_full, input ready);
  modport sink   (input valid, inside_res, any_inside, table_full, output ready);
endinterface

[rtl/core/pip_edge_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_mem
// Edge table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_edge_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/pip_cross_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cross_unit
// Shared three-stage crossing test, one edge per cycle: differences and
// span, cross products, signed compare.
// ----------------------------------------------------------------------------
module pip_cross_unit #(
  parameter int COORD_BITS = 16,
  localparam int D = COORD_BITS + 1,
  localparam int P = 2 * D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         edge_vld,
  input  logic [4*COORD_BITS-1:0]      edge_data,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output pip_pkg::pip_stat_t           stat
);

  localparam int C = COORD_BITS;

  logic signed [C-1:0] x0, y0, x1, y1;
  logic signed [D-1:0] dx_nxt, dy_nxt, t_nxt, u_nxt;
  logic                span_nxt, dxpos_nxt;

  logic                v1_r, v2_r, v3_r;
  logic signed [D-1:0] dx_r, dy_r, t_r, u_r;
  logic                span1_r, dxpos1_r, span2_r, dxpos2_r;
  logic signed [P-1:0] p1_r, p2_r;
  logic signed [P-1:0] p1_nxt, p2_nxt;
  logic                hit_nxt, hit_r;

  always_comb begin
    x0 = $signed(edge_data[4*C-1:3*C]);
    y0 = $signed(edge_data[3*C-1:2*C]);
    x1 = $signed(edge_data[2*C-1:C]);
    y1 = $signed(edge_data[C-1:0]);
    dx_nxt    = D'(x1) - D'(x0);
    dy_nxt    = D'(y1) - D'(y0);
    t_nxt     = D'(px) - D'(x0);
    u_nxt     = D'(py) - D'(y0);
    // half-open span in either direction; empty for vertical edges
    span_nxt  = ((px >= x0) && (px < x1)) || ((px < x0) && (px >= x1));
    dxpos_nxt = x1 > x0;
    p1_nxt    = dy_r * t_r;
    p2_nxt    = u_r * dx_r;
    hit_nxt   = span2_r && (dxpos2_r ? (p1_r <= p2_r) : (p1_r >= p2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= edge_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    t_r      <= t_nxt;
    u_r      <= u_nxt;
    span1_r  <= span_nxt;
    dxpos1_r <= dxpos_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    span2_r  <= span1_r;
    dxpos2_r <= dxpos1_r;
    hit_r    <= hit_nxt;
  end

  assign stat.busy    = v1_r | v2_r | v3_r;
  assign stat.hit_vld = v3_r;
  assign stat.hit     = v3_r & hit_r;

  a_stage_chain: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> $past(v2_r)) else $error("stage 3 valid without stage 2");
  a_edge_to_hit: assert property (@(posedge clk) disable iff (!rst_n)
    edge_vld |=> ##2 stat.hit_vld) else $error("edge lost in crossing unit");
  a_no_phantom_hit: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hit |-> stat.hit_vld) else $error("hit without valid");

endmodule

[rtl/core/point_in_polygon_crossing.sv]
`timescale 1ns / 1ps
// Clear, add edge and unused codes: result registered in the cycle after the beat.
// Test point: one edge per cycle through the edge memory read port and the
// shared crossing unit, then pipeline drain; an empty table goes straight to
// the drain state. One item at a time; a new beat is taken once the block
// is idle and the output register is free. Synchronous active-low reset empties
// the table count and the group flag; edge contents stay undefined until written.
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// Crossing-number point-in-polygon test over a loaded table of edges.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing #(
  parameter int MAX_EDGES  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pip_in_if.sink    in_bus,
  pip_out_if.source out_bus
);

  localparam int COORD_BITS = pip_pkg::COORD_BITS;
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int IDX_W  = $clog2(MAX_EDGES);
  localparam int EDGE_W = 4 * COORD_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         grp_any_r, grp_any_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic                         rd_vld_r;
  logic                         parity_r, parity_nxt;
  logic signed [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                         last_r, last_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_inside_r, out_inside_nxt;
  logic                         out_any_r, out_any_nxt;
  logic                         out_full_r, out_full_nxt;

  logic                         accept, out_free;
  logic                         wr_en, rd_en;
  logic [IDX_W-1:0]             last_idx;
  logic [EDGE_W-1:0]            rd_data;
  logic                         any_now;
  pip_pkg::pip_stat_t           stat;

  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && out_free;
  assign accept       = in_bus.valid && in_bus.ready;
  assign last_idx     = IDX_W'(cnt_r - CNT_W'(1));
  assign any_now      = grp_any_r | parity_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    grp_any_nxt    = grp_any_r;
    idx_nxt        = idx_r;
    parity_nxt     = parity_r ^ stat.hit;
    px_nxt         = px_r;
    py_nxt         = py_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_inside_nxt = out_inside_r;
    out_any_nxt    = out_any_r;
    out_full_nxt   = out_full_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_bus.func)
            pip_pkg::FUNC_TEST: begin
              px_nxt     = in_bus.ax;
              py_nxt     = in_bus.ay;
              last_nxt   = in_bus.last_point;
              parity_nxt = 1'b0;
              idx_nxt    = '0;
              state_nxt  = (cnt_r == '0) ? S_DRAIN : S_SCAN;
            end
            default: begin
              // single-beat commands answer at once
              out_valid_nxt  = 1'b1;
              out_inside_nxt = 1'b0;
              out_any_nxt    = 1'b0;
              out_full_nxt   = 1'b0;
              if (in_bus.func == pip_pkg::FUNC_CLEAR) begin
                cnt_nxt = '0;
              end else if (in_bus.func == pip_pkg::FUNC_ADD) begin
                if (cnt_r == CNT_W'(MAX_EDGES)) begin
                  out_full_nxt = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (idx_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // hold until every edge result is folded into the parity and the output register is free
        if (!rd_vld_r && !stat.busy && out_free) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = parity_r;
          out_any_nxt    = any_now;
          out_full_nxt   = 1'b0;
          grp_any_nxt    = last_r ? 1'b0 : any_now;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      grp_any_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      grp_any_r   <= grp_any_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    parity_r     <= parity_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    last_r       <= last_nxt;
    out_inside_r <= out_inside_nxt;
    out_any_r    <= out_any_nxt;
    out_full_r   <= out_full_nxt;
  end

  pip_edge_mem #(
    .DEPTH (MAX_EDGES),
    .WIDTH (EDGE_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r[IDX_W-1:0]),
    .wr_data   ({in_bus.ax, in_bus.ay, in_bus.bx, in_bus.by}),
    .rd_en     (rd_en),
    .rd_addr   (idx_r),
    .rd_data_r (rd_data)
  );

  pip_cross_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .edge_vld  (rd_vld_r),
    .edge_data (rd_data),
    .px        (px_r),
    .py        (py_r),
    .stat      (stat)
  );

  assign out_bus.valid      = out_valid_r;
  assign out_bus.inside_res = out_inside_r;
  assign out_bus.any_inside = out_any_r;
  assign out_bus.table_full = out_full_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_EDGES)) else $error("edge count beyond table");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !stat.busy && !rd_vld_r) else $error("edges in flight while idle");
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> cnt_r == CNT_W'(MAX_EDGES))
    else $error("table_full flagged with room left");
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == S_SCAN) else $error("edge read outside scan");

endmodule

[sim/pip_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker
// Watches the command and result channels of the crossing block. It keeps
// its own copy of the edge table, the edge count and the group flag,
// predicts one verdict per command beat, and compares each result beat
// field by field with the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module pip_checker #(
  parameter int MAX_EDGES = 32
) (
  input  logic clk,
  input  logic rst_n,
  pip_in_if    in_mon,
  pip_out_if   out_mon,
  output int   fail_count,
  output int   awaiting
);

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic inside_res;
    logic any_inside;
    logic table_full;
  } verdict_t;

  logic signed [15:0] seg_x0 [MAX_EDGES];
  logic signed [15:0] seg_y0 [MAX_EDGES];
  logic signed [15:0] seg_x1 [MAX_EDGES];
  logic signed [15:0] seg_y1 [MAX_EDGES];
  int                 seg_count;
  logic               group_hit;
  int                 mismatches;
  verdict_t           pending_verdicts [$];
  verdict_t           want;
  verdict_t           fresh;

  // Exact height test: cross-multiplied, no slope.
  function automatic logic seg_crosses(int k, longint px, longint py);
    longint x0, y0, x1, y1, dx, dy, lhs, rhs;
    x0 = seg_x0[k];
    y0 = seg_y0[k];
    x1 = seg_x1[k];
    y1 = seg_y1[k];
    if (!((px >= x0 && px < x1) || (px < x0 && px >= x1)))
      return 1'b0;
    dx  = x1 - x0;
    dy  = y1 - y0;
    lhs = dy * (px - x0);
    rhs = (py - y0) * dx;
    return (dx > 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  task automatic crossing_verdict(input logic [1:0] func,
                                  input logic signed [15:0] ax, ay, bx, by,
                                  input logic last, output verdict_t v);
    int hits;
    v    = '0;
    hits = 0;
    case (func)
      pip_pkg::FUNC_CLEAR: seg_count = 0;
      pip_pkg::FUNC_ADD: begin
        if (seg_count >= MAX_EDGES) begin
          v.table_full = 1'b1;
        end else begin
          seg_x0[seg_count] = ax;
          seg_y0[seg_count] = ay;
          seg_x1[seg_count] = bx;
          seg_y1[seg_count] = by;
          seg_count++;
        end
      end
      pip_pkg::FUNC_TEST: begin
        for (int k = 0; k < seg_count; k++)
          if (seg_crosses(k, ax, ay)) hits++;
        v.inside_res = hits[0];
        v.any_inside = group_hit | hits[0];
        group_hit    = last ? 1'b0 : v.any_inside;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_CAP)
      $display("pip_checker: %s at %0t", what, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_count  = 0;
      group_hit  = 1'b0;
      mismatches = 0;
      pending_verdicts.delete();
    end else begin
      // Check results first: a result never belongs to a beat of this edge.
      if (out_mon.valid && out_mon.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result beat with no verdict outstanding");
        end else begin
          want = pending_verdicts.pop_front();
          if (out_mon.inside_res !== want.inside_res)
            report_mismatch($sformatf("inside_res got %b want %b",
                                      out_mon.inside_res, want.inside_res));
          if (out_mon.any_inside !== want.any_inside)
            report_mismatch($sformatf("any_inside got %b want %b",
                                      out_mon.any_inside, want.any_inside));
          if (out_mon.table_full !== want.table_full)
            report_mismatch($sformatf("table_full got %b want %b",
                                      out_mon.table_full, want.table_full));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        crossing_verdict(in_mon.func, in_mon.ax, in_mon.ay, in_mon.bx, in_mon.by,
                         in_mon.last_point, fresh);
        pending_verdicts.push_back(fresh);
      end
    end
    fail_count <= mismatches;
    awaiting   <= pending_verdicts.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the point-in-polygon block with a directed set of edge and point
// beats, then random closed polygons probed by groups of points, overfilled
// tables and noise, under three idling phases and long result hold-offs.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         MAX_EDGES      = 32;
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         ITEMS_TOTAL    = 1100;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = MAX_EDGES + 16;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   awaiting;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   hold_reqs;
  int   holds_served;
  int   items_sent;
  int   edges_loaded;
  int   phase;

  pip_in_if  in_bus ();
  pip_out_if out_bus ();

  point_in_polygon_crossing #(
    .MAX_EDGES (MAX_EDGES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  pip_checker #(
    .MAX_EDGES(MAX_EDGES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .fail_count(fail_count),
    .awaiting  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random ready, or a long hold-off when one is requested.
  initial begin
    out_bus.ready = 1'b0;
    holds_served  = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served <= holds_served + 1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic [15:0] rnd16();
    logic [31:0] r;
    r = $urandom();
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] pick_coord(int span);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_beat(input logic [1:0] func, input logic signed [15:0] x0, y0,
                           x1, y1, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.ax         <= x0;
    in_bus.ay         <= y0;
    in_bus.bx         <= x1;
    in_bus.by         <= y1;
    in_bus.last_point <= last;
    do @(posedge clk); while (!in_bus.ready);
    if (func != FUNC_UNUSED) items_sent++;
    if (func == pip_pkg::FUNC_CLEAR)
      edges_loaded = 0;
    else if (func == pip_pkg::FUNC_ADD && edges_loaded < MAX_EDGES)
      edges_loaded++;
  endtask

  task automatic probe(input logic signed [15:0] px, py, input logic last);
    send_beat(pip_pkg::FUNC_TEST, px, py, rnd16(), rnd16(), last);
  endtask

  task automatic add_seg(input logic signed [15:0] x0, y0, x1, y1);
    send_beat(pip_pkg::FUNC_ADD, x0, y0, x1, y1, 1'($urandom_range(1)));
  endtask

  // Load a closed polygon, maybe overfill the table, then probe a group.
  task automatic load_and_probe(input bit force_full);
    logic signed [15:0] vx [MAX_EDGES];
    logic signed [15:0] vy [MAX_EDGES];
    logic signed [15:0] px;
    logic signed [15:0] py;
    int                 n_vert;
    int                 n_probe;
    int                 span;
    int                 j;
    logic               last;
    case ($urandom_range(3))
      0:       span = 12;
      1:       span = 300;
      2:       span = 9000;
      default: span = 32767;
    endcase
    n_vert = ($urandom_range(7) == 0) ? int'($urandom_range(9, MAX_EDGES))
                                      : int'($urandom_range(3, 8));
    for (int k = 0; k < n_vert; k++) begin
      vx[k] = pick_coord(span);
      vy[k] = pick_coord(span);
    end
    // Skip the clear now and then so edges pile up across polygons.
    if (force_full || $urandom_range(9) != 0)
      send_beat(pip_pkg::FUNC_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(),
                1'($urandom_range(1)));
    for (int k = 0; k < n_vert; k++) begin
      j = (k + 1) % n_vert;
      add_seg(vx[k], vy[k], vx[j], vy[j]);
    end
    if (force_full || $urandom_range(7) == 0)
      repeat (MAX_EDGES - edges_loaded + int'($urandom_range(1, 3)))
        add_seg(pick_coord(span), pick_coord(span), pick_coord(span), pick_coord(span));
    n_probe = $urandom_range(1, 6);
    for (int k = 0; k < n_probe; k++) begin
      j = $urandom_range(n_vert - 1);
      case ($urandom_range(7))
        0, 1: begin
          px = vx[j];
          py = vy[j];
        end
        2: begin
          px = vx[j] + 16'sd1;
          py = vy[j];
        end
        default: begin
          px = pick_coord(span);
          py = pick_coord(span);
        end
      endcase
      // Mostly close the group on the final point; leave it open sometimes.
      if (k == n_probe - 1)
        last = ($urandom_range(5) != 0);
      else
        last = ($urandom_range(9) == 0);
      probe(px, py, last);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.func       = pip_pkg::FUNC_CLEAR;
    in_bus.ax         = '0;
    in_bus.ay         = '0;
    in_bus.bx         = '0;
    in_bus.by         = '0;
    in_bus.last_point = 1'b0;
    src_idle_pct      = 38;
    sink_idle_pct     = 88;
    hold_reqs         = 0;
    items_sent        = 0;
    edges_loaded      = 0;
    phase             = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, then an unused code that must leave no trace.
    probe(16'sd5, 16'sd5, 1'b0);
    send_beat(FUNC_UNUSED, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1);
    send_beat(pip_pkg::FUNC_CLEAR, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    // Full-range square with two vertical sides, plus a zero-length edge.
    add_seg(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    add_seg(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
    add_seg(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
    add_seg(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
    add_seg(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    probe(16'sd0, 16'sd0, 1'b0);
    probe(16'sh8000, 16'sh8000, 1'b0);
    probe(16'sh7fff, 16'sh7fff, 1'b1);
    probe(16'sh7fff, 16'sd0, 1'b1);
    probe(-16'sd1, 16'sh8000, 1'b0);
    // Clear keeps the open group flag.
    send_beat(pip_pkg::FUNC_CLEAR, '0, '0, '0, '0, 1'b0);
    probe(16'sd0, 16'sd0, 1'b1);
    add_seg(-16'sd10, -16'sd10, 16'sd10, -16'sd10);
    add_seg(16'sd10, -16'sd10, 16'sd0, 16'sd10);
    add_seg(16'sd0, 16'sd10, -16'sd10, -16'sd10);
    probe(16'sd0, 16'sd0, 1'b0);
    probe(16'sd0, 16'sd10, 1'b0);
    probe(-16'sd10, -16'sd10, 1'b1);
    probe(16'sd20, 16'sd20, 1'b1);
    send_beat(FUNC_UNUSED, '0, '0, '0, '0, 1'b0);
    probe(16'sd0, -16'sd10, 1'b1);

    load_and_probe(1'b1);
    while (items_sent < ITEMS_TOTAL) begin
      if (phase == 0 && items_sent >= ITEMS_TOTAL / 3) begin
        phase         = 1;
        src_idle_pct  = 88;
        sink_idle_pct <= 38;
        hold_reqs     <= hold_reqs + 1;
      end else if (phase == 1 && items_sent >= 2 * ITEMS_TOTAL / 3) begin
        phase         = 2;
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        hold_reqs     <= hold_reqs + 1;
      end
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 4))
          send_beat(2'($urandom_range(3)), rnd16(), rnd16(), rnd16(), rnd16(),
                    1'($urandom_range(1)));
      else
        load_and_probe(1'b0);
    end
    in_bus.valid <= 1'b0;

    // Let the checker count the final beat before waiting on it.
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaiting == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/core/pip_pkg.sv
rtl/core/pip_ifs.sv
rtl/core/pip_edge_mem.sv
rtl/core/pip_cross_unit.sv
rtl/core/point_in_polygon_crossing.sv
sim/pip_checker.sv
sim/tb_top.sv
